// ===== rtl/core/qrs_pkg.sv =====
`default_nettype none
package qrs_pkg;

  localparam int OUT_WIDTH = 35;

  typedef enum logic [1:0] {
    KIND_DOUBLE  = 2'd0,
    KIND_TWO     = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_DEGEN   = 2'd3
  } kind_e;

endpackage
`default_nettype wire

// ===== rtl/core/qrs_in_if.sv =====
`default_nettype none
interface qrs_in_if #(
  parameter int COEFF_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COEFF_WIDTH-1:0] coeff_a;
  logic signed [COEFF_WIDTH-1:0] coeff_b;
  logic signed [COEFF_WIDTH-1:0] coeff_c;

  modport source (output valid, output coeff_a, output coeff_b, output coeff_c, input ready);
  modport sink   (input valid, input coeff_a, input coeff_b, input coeff_c, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/qrs_out_if.sv =====
`default_nettype none
interface qrs_out_if ();
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           root_kind;
  logic signed [qrs_pkg::OUT_WIDTH-1:0] first_root_real;
  logic signed [qrs_pkg::OUT_WIDTH-1:0] second_root_real;
  logic signed [qrs_pkg::OUT_WIDTH-1:0] imaginary_part;

  modport source (output valid, output root_kind, output first_root_real,
                  output second_root_real, output imaginary_part, input ready);
  modport sink   (input valid, input root_kind, input first_root_real,
                  input second_root_real, input imaginary_part, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/qrs_front.sv =====
`default_nettype none
module qrs_front #(
  parameter int COEFF_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COEFF_WIDTH-1:0] coeff_a_i,
  input  logic signed [COEFF_WIDTH-1:0] coeff_b_i,
  input  logic signed [COEFF_WIDTH-1:0] coeff_c_i,
  output logic                          item_valid_o,
  input  logic                          item_ready_i,
  output logic [4*COEFF_WIDTH+5:0]      item_o
);
  localparam int W  = COEFF_WIDTH;
  localparam int DW = 2 * W + 2;

  typedef struct packed {
    qrs_pkg::kind_e kind;
    logic           an;
    logic           bn;
    logic [W-1:0]   am;
    logic [W-1:0]   bm;
    logic [DW-1:0]  dmag;
  } item_t;

  logic en_a, en_b, en_c;
  logic a_v_q, b_v_q, c_v_q;

  // stage A: magnitudes and signs
  logic [W-1:0] am_q, bm_q, cm_q, am_d, bm_d, cm_d;
  logic         an_q, bn_q, cn_q;
  // stage B: products
  logic [2*W-1:0] bb_q, ac_q;
  logic [W-1:0]   bam_q, bbm_q;
  logic           ban_q, bbn_q, bsub_q;
  // stage C: discriminant and kind
  item_t c_q, c_d;

  logic [DW-1:0] bb_x, ac4_x;

  assign en_c       = !c_v_q || item_ready_i;
  assign en_b       = !b_v_q || en_c;
  assign en_a       = !a_v_q || en_b;
  assign in_ready_o = en_a;

  assign am_d = coeff_a_i[W-1] ? W'(-coeff_a_i) : W'(coeff_a_i);
  assign bm_d = coeff_b_i[W-1] ? W'(-coeff_b_i) : W'(coeff_b_i);
  assign cm_d = coeff_c_i[W-1] ? W'(-coeff_c_i) : W'(coeff_c_i);

  assign bb_x  = DW'(bb_q);
  assign ac4_x = DW'(ac_q) << 2;

  always_comb begin
    c_d.an = ban_q;
    c_d.bn = bbn_q;
    c_d.am = bam_q;
    c_d.bm = bbm_q;
    c_d.kind = qrs_pkg::KIND_TWO;
    if (bsub_q) begin
      if (bb_x >= ac4_x) begin
        c_d.dmag = bb_x - ac4_x;
      end else begin
        c_d.dmag = ac4_x - bb_x;
        c_d.kind = qrs_pkg::KIND_COMPLEX;
      end
    end else begin
      c_d.dmag = bb_x + ac4_x;
    end
    if (c_d.dmag == '0) c_d.kind = qrs_pkg::KIND_DOUBLE;
    if (bam_q == '0) c_d.kind = qrs_pkg::KIND_DEGEN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= in_valid_i;
      if (en_b) b_v_q <= a_v_q;
      if (en_c) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      am_q <= am_d;
      bm_q <= bm_d;
      cm_q <= cm_d;
      an_q <= coeff_a_i[W-1];
      bn_q <= coeff_b_i[W-1];
      cn_q <= coeff_c_i[W-1];
    end
    if (en_b) begin
      bb_q   <= (2*W)'(bm_q) * (2*W)'(bm_q);
      ac_q   <= (2*W)'(am_q) * (2*W)'(cm_q);
      bam_q  <= am_q;
      bbm_q  <= bm_q;
      ban_q  <= an_q;
      bbn_q  <= bn_q;
      bsub_q <= (an_q == cn_q);
    end
    if (en_c) c_q <= c_d;
  end

  assign item_valid_o = c_v_q;
  assign item_o       = c_q;
endmodule
`default_nettype wire

// ===== rtl/core/qrs_queue.sv =====
`default_nettype none
module qrs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != (AW+1)'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end
endmodule
`default_nettype wire

// ===== rtl/core/qrs_div.sv =====
`default_nettype none
module qrs_div #(
  parameter int NUM_WIDTH  = 8,
  parameter int DEN_WIDTH  = 4,
  parameter int SIDE_WIDTH = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [NUM_WIDTH-1:0]  num1_i,
  input  logic [NUM_WIDTH-1:0]  num2_i,
  input  logic [DEN_WIDTH-1:0]  den_i,
  input  logic [SIDE_WIDTH-1:0] side_i,
  output logic                  valid_o,
  output logic [NUM_WIDTH-1:0]  quot1_o,
  output logic [NUM_WIDTH-1:0]  quot2_o,
  output logic [SIDE_WIDTH-1:0] side_o
);
  localparam int UW  = NUM_WIDTH;
  localparam int DRW = DEN_WIDTH + 1;

  logic                  v_q    [UW];
  logic [DRW-1:0]        r1_q   [UW];
  logic [DRW-1:0]        r2_q   [UW];
  logic [UW-1:0]         q1_q   [UW];
  logic [UW-1:0]         q2_q   [UW];
  logic [UW-1:0]         n1_q   [UW];
  logic [UW-1:0]         n2_q   [UW];
  logic [DEN_WIDTH-1:0]  den_q  [UW];
  logic [SIDE_WIDTH-1:0] side_q [UW];

  for (genvar k = 0; k < UW; k++) begin : g_stage
    logic                  v_in;
    logic [DRW-1:0]        r1_in, r2_in, r1_sh, r2_sh, dx;
    logic [UW-1:0]         q1_in, q2_in, n1_in, n2_in;
    logic [DEN_WIDTH-1:0]  den_in;
    logic [SIDE_WIDTH-1:0] side_in;
    logic                  ge1, ge2;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign r1_in   = '0;
      assign r2_in   = '0;
      assign q1_in   = '0;
      assign q2_in   = '0;
      assign n1_in   = num1_i;
      assign n2_in   = num2_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_body
      assign v_in    = v_q[k-1];
      assign r1_in   = r1_q[k-1];
      assign r2_in   = r2_q[k-1];
      assign q1_in   = q1_q[k-1];
      assign q2_in   = q2_q[k-1];
      assign n1_in   = n1_q[k-1];
      assign n2_in   = n2_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dx    = DRW'(den_in);
    assign r1_sh = {r1_in[DRW-2:0], n1_in[UW-1-k]};
    assign r2_sh = {r2_in[DRW-2:0], n2_in[UW-1-k]};
    assign ge1   = (r1_sh >= dx);
    assign ge2   = (r2_sh >= dx);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k] <= 1'b0;
      else if (en_i) v_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r1_q[k]   <= ge1 ? r1_sh - dx : r1_sh;
        r2_q[k]   <= ge2 ? r2_sh - dx : r2_sh;
        q1_q[k]   <= {q1_in[UW-2:0], ge1};
        q2_q[k]   <= {q2_in[UW-2:0], ge2};
        n1_q[k]   <= n1_in;
        n2_q[k]   <= n2_in;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[UW-1];
  assign quot1_o = q1_q[UW-1];
  assign quot2_o = q2_q[UW-1];
  assign side_o  = side_q[UW-1];
endmodule
`default_nettype wire

// ===== rtl/core/qrs_back.sv =====
`default_nettype none
module qrs_back #(
  parameter int COEFF_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 item_valid_i,
  output logic                                 item_ready_o,
  input  logic [4*COEFF_WIDTH+5:0]             item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           root_kind_o,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] first_root_real_o,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] second_root_real_o,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] imaginary_part_o
);
  localparam int W   = COEFF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * W + 2;
  localparam int SW  = W + 1 + F;
  localparam int VW  = 2 * SW;
  localparam int RW  = SW + 2;
  localparam int NW  = W + F + 3;
  localparam int OW  = qrs_pkg::OUT_WIDTH;
  localparam int QX  = (NW > OW + 1) ? NW : OW + 1;
  localparam int SDW = 4;

  typedef struct packed {
    qrs_pkg::kind_e kind;
    logic           an;
    logic           bn;
    logic [W-1:0]   am;
    logic [W-1:0]   bm;
    logic [DW-1:0]  dmag;
  } item_t;

  typedef struct packed {
    qrs_pkg::kind_e kind;
    logic           an;
    logic           bn;
    logic [W-1:0]   am;
    logic [W-1:0]   bm;
  } side_t;

  typedef struct packed {
    qrs_pkg::kind_e kind;
    logic           neg1;
    logic           neg2;
  } dside_t;

  function automatic logic signed [OW-1:0] to_field(input logic [NW-1:0] q, input logic neg);
    logic [QX-1:0] qx, lim_neg, lim_pos, m;
    qx      = QX'(q);
    lim_neg = QX'(1) << (OW - 1);
    lim_pos = lim_neg - 1'b1;
    if (neg) begin
      m = (qx > lim_neg) ? lim_neg : qx;
      m = -m;
    end else begin
      m = (qx > lim_pos) ? lim_pos : qx;
    end
    return m[OW-1:0];
  endfunction

  item_t item;
  logic  en;

  assign item         = item_i;
  assign en           = !out_valid_o || out_ready_i;
  assign item_ready_o = en;

  // square root, one result bit per stage
  logic          sv_q   [SW];
  logic [RW-1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [VW-1:0] rad_q  [SW];
  side_t         sd_q   [SW];

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic          v_in;
    logic [RW-1:0] rem_in, rem_sh, trial;
    logic [SW-1:0] root_in;
    logic [VW-1:0] rad_in;
    side_t         sd_in;
    logic          ge;

    if (k == 0) begin : g_head
      assign v_in    = item_valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = VW'(item.dmag) << (2 * F);
      assign sd_in   = '{kind: item.kind, an: item.an, bn: item.bn, am: item.am, bm: item.bm};
    end else begin : g_body
      assign v_in    = sv_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign sd_in   = sd_q[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], rad_in[VW-1-2*k -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k] <= 1'b0;
      else if (en) sv_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[SW-2:0], ge};
        rad_q[k]  <= rad_in;
        sd_q[k]   <= sd_in;
      end
    end
  end

  // numerators
  side_t                sn;
  logic signed [NW-1:0] pbx, pbs, sx, n1_d, n2_d;
  logic signed [NW-1:0] n1_q, n2_q;
  logic                 nv_q;
  side_t                ns_q;

  assign sn   = sd_q[SW-1];
  assign pbx  = NW'((W+F)'(sn.bm) << F);
  assign pbs  = sn.bn ? pbx : -pbx;
  assign sx   = NW'(root_q[SW-1]);
  assign n1_d = (sn.kind == qrs_pkg::KIND_COMPLEX) ? pbs : pbs + sx;
  assign n2_d = (sn.kind == qrs_pkg::KIND_COMPLEX) ? sx  : pbs - sx;

  // rounding offset and sign
  logic [NW-1:0] p1_q, p2_q, m1, m2;
  logic [W:0]    pden_q;
  logic          pv_q;
  dside_t        ps_q;

  assign m1 = n1_q[NW-1] ? NW'(-n1_q) : NW'(n1_q);
  assign m2 = n2_q[NW-1] ? NW'(-n2_q) : NW'(n2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
      pv_q <= 1'b0;
    end else if (en) begin
      nv_q <= sv_q[SW-1];
      pv_q <= nv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q      <= n1_d;
      n2_q      <= n2_d;
      ns_q      <= sn;
      p1_q      <= m1 + NW'(ns_q.am);
      p2_q      <= m2 + NW'(ns_q.am);
      pden_q    <= {ns_q.am, 1'b0};
      ps_q.kind <= ns_q.kind;
      ps_q.neg1 <= n1_q[NW-1] ^ ns_q.an;
      ps_q.neg2 <= n2_q[NW-1] ^ ns_q.an;
    end
  end

  logic          dv;
  logic [NW-1:0] q1, q2;
  dside_t        ds;

  qrs_div #(
    .NUM_WIDTH (NW),
    .DEN_WIDTH (W + 1),
    .SIDE_WIDTH(SDW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(pv_q),
    .num1_i (p1_q),
    .num2_i (p2_q),
    .den_i  (pden_q),
    .side_i (ps_q),
    .valid_o(dv),
    .quot1_o(q1),
    .quot2_o(q2),
    .side_o (ds)
  );

  // output register
  logic                 ov_q;
  logic [1:0]           ok_q;
  logic signed [OW-1:0] o1_q, o2_q, oi_q, f1, f2;

  assign f1 = to_field(q1, ds.neg1);
  assign f2 = to_field(q2, ds.neg2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= dv;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= ds.kind;
      unique case (ds.kind)
        qrs_pkg::KIND_DEGEN: begin
          o1_q <= '0;
          o2_q <= '0;
          oi_q <= '0;
        end
        qrs_pkg::KIND_COMPLEX: begin
          o1_q <= f1;
          o2_q <= f1;
          oi_q <= f2;
        end
        default: begin
          o1_q <= f1;
          o2_q <= f2;
          oi_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o        = ov_q;
  assign root_kind_o        = ok_q;
  assign first_root_real_o  = o1_q;
  assign second_root_real_o = o2_q;
  assign imaginary_part_o   = oi_q;
endmodule
`default_nettype wire

// ===== rtl/core/quadratic_root_solver.sv =====
`default_nettype none
// Quadratic root solver: takes signed coefficients a, b, c and returns the kind
// of roots (double real, two real, complex pair, or degenerate when a is zero)
// together with both real parts and the imaginary part in signed fixed point
// with FRAC_BITS fraction bits, each quotient rounded to nearest with ties away
// from zero and saturated to 35 bits. The block takes one word per cycle unless
// a stalled output holds it back. A front pipeline (stages A, B and C) forms the
// discriminant; a 2-entry queue then feeds the back pipeline: a square root with
// one stage per root bit (COEFF_WIDTH+FRAC_BITS+1 stages), 2 numerator stages, a
// restoring divider with one stage per quotient bit (COEFF_WIDTH+FRAC_BITS+3
// stages) and the output register. The back pipeline stalls as a whole when the
// output word is not taken.
module quadratic_root_solver #(
  parameter int COEFF_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qrs_in_if.sink      in_i,
  qrs_out_if.source   out_o
);
  localparam int IW = 4 * COEFF_WIDTH + 6;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [IW-1:0] f_item, b_item;

  qrs_front #(.COEFF_WIDTH(COEFF_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .coeff_a_i   (in_i.coeff_a),
    .coeff_b_i   (in_i.coeff_b),
    .coeff_c_i   (in_i.coeff_c),
    .item_valid_o(f_valid),
    .item_ready_i(f_ready),
    .item_o      (f_item)
  );

  qrs_queue #(.WIDTH(IW), .DEPTH(2)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_data_i  (f_item),
    .out_valid_o(b_valid),
    .out_ready_i(b_ready),
    .out_data_o (b_item)
  );

  qrs_back #(.COEFF_WIDTH(COEFF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (b_valid),
    .item_ready_o      (b_ready),
    .item_i            (b_item),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .root_kind_o       (out_o.root_kind),
    .first_root_real_o (out_o.first_root_real),
    .second_root_real_o(out_o.second_root_real),
    .imaginary_part_o  (out_o.imaginary_part)
  );
endmodule
`default_nettype wire

// ===== tb/tb_quadratic_root_solver.sv =====
`timescale 1ns / 1ps
module tb_quadratic_root_solver;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int LATENCY = 2 * CW + 2 * FB + 11;
  localparam int N_RANDOM = 1250;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [34:0] OUT_MAX = 35'sh3_FFFF_FFFF;
  localparam logic signed [34:0] OUT_MIN = -35'sh4_0000_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [34:0] re1;
    logic signed [34:0] re2;
    logic signed [34:0] im;
  } roots_t;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic               typed;
    roots_t             res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  longint cycles = 0;
  int errors = 0;
  int n_sent, n_got = 0;
  int n_kind[4];
  bit rx_done;
  roots_t roots_q[$];

  qrs_in_if #(.COEFF_WIDTH(CW)) in_if ();
  qrs_out_if out_if ();

  quadratic_root_solver #(.COEFF_WIDTH(CW), .FRAC_BITS(FB)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Round N / (2a) to nearest, ties away from zero, then saturate.
  function automatic logic signed [34:0] div_2a(logic signed [127:0] num,
                                                 logic signed [127:0] a);
    logic [127:0] nm;
    logic [127:0] am;
    logic [127:0] q;
    logic         neg;
    nm = num < 0 ? -num : num;
    am = a < 0 ? -a : a;
    q = (nm + am) / (2 * am);
    neg = (num < 0) != (a < 0);
    if (q == 0) return '0;
    if (neg) return (q > 128'h4_0000_0000) ? OUT_MIN : -$signed(q[34:0]);
    return (q > 128'h3_FFFF_FFFF) ? OUT_MAX : $signed(q[34:0]);
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] r;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      if ((r | (128'd1 << i)) * (r | (128'd1 << i)) <= v) r = r | (128'd1 << i);
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] a, logic signed [15:0] b,
                                         logic signed [15:0] c);
    roots_t r;
    logic signed [127:0] sa, sb, sc, disc, pb, s;
    sa = 128'(a); sb = 128'(b); sc = 128'(c);
    r = '0;
    if (a == 0) begin
      r.kind = qrs_pkg::KIND_DEGEN;
      return r;
    end
    disc = sb * sb - 4 * sa * sc;
    if (disc == 0) r.kind = qrs_pkg::KIND_DOUBLE;
    else if (disc < 0) r.kind = qrs_pkg::KIND_COMPLEX;
    else r.kind = qrs_pkg::KIND_TWO;
    s = $signed(isqrt((disc < 0 ? -disc : disc) << (2 * FB)));
    pb = -(sb <<< FB);
    if (r.kind == qrs_pkg::KIND_COMPLEX) begin
      r.re1 = div_2a(pb, sa);
      r.re2 = r.re1;
      r.im = div_2a(s, sa);
    end else begin
      r.re1 = div_2a(pb + s, sa);
      r.re2 = div_2a(pb - s, sa);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch at word %0d: %s got %h expected %h", n_got, what, got, want);
  endtask

  task automatic send_word(logic signed [15:0] a, logic signed [15:0] b,
                           logic signed [15:0] c, bit typed, roots_t res);
    roots_t p;
    p = solve_roots(a, b, c);
    if (typed && p !== res) begin
      errors++;
      $display("table row %0d disagrees with prediction", n_sent);
    end
    in_if.coeff_a <= a;
    in_if.coeff_b <= b;
    in_if.coeff_c <= c;
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    roots_q.push_back(typed ? res : p);
    n_kind[p.kind]++;
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return $signed(16'($urandom_range(0, 15)) - 16'd8);
      3: return $signed(16'($urandom_range(0, 511)) - 16'd256);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  // Receiver: stall on a rotating pattern, check each word.
  initial begin
    int ph;
    out_if.ready = 1'b0;
    ph = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      ph++;
      if (ph % 300 < 60) out_if.ready <= 1'b1;
      else out_if.ready <= (ph % 7 != 3) && ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    roots_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (roots_q.size() == 0) begin
        errors++;
        $display("result word with nothing expected");
      end else begin
        want = roots_q.pop_front();
        if (out_if.root_kind !== want.kind)
          report_mismatch("root_kind", 64'(out_if.root_kind), 64'(want.kind));
        if (out_if.first_root_real !== want.re1)
          report_mismatch("first_root_real", 64'(out_if.first_root_real), 64'(want.re1));
        if (out_if.second_root_real !== want.re2)
          report_mismatch("second_root_real", 64'(out_if.second_root_real),
                          64'(want.re2));
        if (out_if.imaginary_part !== want.im)
          report_mismatch("imaginary_part", 64'(out_if.imaginary_part), 64'(want.im));
      end
      n_got++;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    row_t dir[$];
    roots_t z;
    int burst;
    int gap;
    n_sent = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.coeff_a = '0;
    in_if.coeff_b = '0;
    in_if.coeff_c = '0;
    z = '0;
    // a, b, c, typed, expected
    dir.push_back('{16'sd0, 16'sd5, 16'sd7, 1'b1,
                    '{qrs_pkg::KIND_DEGEN, 35'sd0, 35'sd0, 35'sd0}});
    dir.push_back('{16'sd0, 16'sh8000, 16'sh7FFF, 1'b1,
                    '{qrs_pkg::KIND_DEGEN, 35'sd0, 35'sd0, 35'sd0}});
    dir.push_back('{16'sd1, 16'sd0, 16'sd0, 1'b1,
                    '{qrs_pkg::KIND_DOUBLE, 35'sd0, 35'sd0, 35'sd0}});
    dir.push_back('{16'sd1, -16'sd2, 16'sd1, 1'b1,
                    '{qrs_pkg::KIND_DOUBLE, 35'sd65536, 35'sd65536, 35'sd0}});
    dir.push_back('{16'sd1, 16'sd0, -16'sd1, 1'b1,
                    '{qrs_pkg::KIND_TWO, 35'sd65536, -35'sd65536, 35'sd0}});
    dir.push_back('{16'sd1, 16'sd0, 16'sd1, 1'b1,
                    '{qrs_pkg::KIND_COMPLEX, 35'sd0, 35'sd0, 35'sd65536}});
    dir.push_back('{-16'sd1, 16'sd0, -16'sd1, 1'b1,
                    '{qrs_pkg::KIND_COMPLEX, 35'sd0, 35'sd0, -35'sd65536}});
    dir.push_back('{16'sd1, 16'sh8000, 16'sd0, 1'b0, z});
    dir.push_back('{16'sd1, 16'sh7FFF, 16'sh8000, 1'b0, z});
    dir.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, z});
    dir.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, z});
    dir.push_back('{16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, z});
    dir.push_back('{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, z});
    dir.push_back('{-16'sd1, 16'sd3, 16'sh7FFF, 1'b0, z});
    dir.push_back('{16'sd2, 16'sd1, 16'sd0, 1'b0, z});
    dir.push_back('{16'sd4, 16'sd1, 16'sd0, 1'b0, z});
    dir.push_back('{16'sd3, 16'sd7, -16'sd5, 1'b0, z});
    dir.push_back('{16'shFFFF, 16'sh5555, 16'shAAAA, 1'b0, z});
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir[i]) send_word(dir[i].a, dir[i].b, dir[i].c, dir[i].typed, dir[i].res);
    in_if.valid <= 1'b0;
    // Drain fully once before the random part.
    while (roots_q.size() != 0) @(negedge clk_i);
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        logic signed [15:0] a, b, c;
        int da, dk;
        a = rand_coeff();
        b = rand_coeff();
        c = rand_coeff();
        if ($urandom_range(0, 9) == 0) begin
          // b = 2ak and c = ak^2 give b^2 = 4ac: double root
          da = $urandom_range(1, 100);
          dk = $urandom_range(0, 18);
          a = 16'(da);
          b = 16'(($urandom_range(0, 1) ? 2 : -2) * da * dk);
          c = 16'(da * dk * dk);
        end
        send_word(a, b, c, 1'b0, z);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_if.valid <= 1'b0;
    while (roots_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("sent %0d equations: %0d double, %0d two real, %0d complex, %0d degenerate",
             n_sent, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== quadratic_root_solver.f =====
rtl/core/qrs_pkg.sv
rtl/core/qrs_in_if.sv
rtl/core/qrs_out_if.sv
rtl/core/qrs_front.sv
rtl/core/qrs_queue.sv
rtl/core/qrs_div.sv
rtl/core/qrs_back.sv
rtl/core/quadratic_root_solver.sv
tb/tb_quadratic_root_solver.sv
